### rtl/core/qfa_pkg.sv
// Package for the Q-format fixed-point ALU: request, response and control types,
// opcodes, status codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qfa_pkg;

	localparam int unsigned ACT_W      = 4;
	localparam int unsigned FIELD_W    = 32;
	localparam int unsigned FRAC_W     = 5;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned FRAC_MAX   = (1 << FRAC_W) - 1;

	localparam logic [ACT_W-1:0] ACT_ADD   = 4'd0;
	localparam logic [ACT_W-1:0] ACT_SUB   = 4'd1;
	localparam logic [ACT_W-1:0] ACT_MUL   = 4'd2;
	localparam logic [ACT_W-1:0] ACT_DIV   = 4'd3;
	localparam logic [ACT_W-1:0] ACT_CADD  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_CSUB  = 4'd5;
	localparam logic [ACT_W-1:0] ACT_CMUL  = 4'd6;
	localparam logic [ACT_W-1:0] ACT_CDIV  = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CONV  = 4'd8;
	localparam logic [ACT_W-1:0] ACT_FLOOR = 4'd9;
	localparam logic [ACT_W-1:0] ACT_CEIL  = 4'd10;
	localparam logic [ACT_W-1:0] ACT_ROUND = 4'd11;
	localparam logic [ACT_W-1:0] ACT_ABS   = 4'd12;

	localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INV = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 8'd1;

	localparam logic [FRAC_W-1:0] FRAC_RESET   = 5'd16;
	localparam logic              SIGNED_RESET = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [FIELD_W-1:0] operand_a;
		logic [FIELD_W-1:0] operand_b;
		logic [FRAC_W-1:0]  target_frac_bits;
	} qfa_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] value;
		logic [STAT_W-1:0]  status;
	} qfa_rsp_t;

	typedef struct packed {
		logic              valid;
		logic [ACT_W-1:0]  action;
		logic [FRAC_W-1:0] n;
		logic              sgn;
		logic              neg;
		logic              bzero;
		logic [STAT_W-1:0] status_pre;
	} qfa_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/qfa_front.sv
// Input stage of the Q-format ALU: operand extension, magnitudes, the short
// operations and the load of the multiply/divide cell chain. Uses qfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qfa_front #(
	parameter int WIDTH = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  qfa_pkg::qfa_req_t         req,
	input  wire [qfa_pkg::FRAC_W-1:0] frac_bits,
	input  wire                       signed_mode,
	output qfa_pkg::qfa_ctrl_t        ctrl_s1,
	output logic [WIDTH+qfa_pkg::FRAC_MAX-1:0] num_s1,
	output logic [WIDTH-1:0]          mb_s1,
	output logic [WIDTH-1:0]          early_s1
);

	localparam int NW = WIDTH + qfa_pkg::FRAC_MAX;

	logic [WIDTH-1:0] a_w, b_w, ma, mb, sum, diff;
	logic [WIDTH-1:0] unit_w, fm_w, half_w, floor_w, early;
	logic             a_neg, b_neg, bzero, n_bad;
	logic [qfa_pkg::FRAC_W-1:0]  n, nt;
	logic [qfa_pkg::STAT_W-1:0]  status;
	logic [NW-1:0]    num;

	always_comb begin
		n     = frac_bits;
		nt    = req.target_frac_bits;
		a_w   = WIDTH'(req.operand_a);
		b_w   = WIDTH'(req.operand_b);
		a_neg = signed_mode & a_w[WIDTH-1];
		b_neg = signed_mode & b_w[WIDTH-1];
		ma    = a_neg ? (~a_w + 1'b1) : a_w;
		mb    = b_neg ? (~b_w + 1'b1) : b_w;
		bzero = (b_w == '0);
		n_bad = signed_mode ? (int'(n) > WIDTH - 2) : (int'(n) > WIDTH - 1);
		sum   = a_w + b_w;
		diff  = a_w - b_w;
		// A unit at or above the word width truncates away entirely.
		unit_w  = (int'(n) < WIDTH) ? (WIDTH'(1) << n) : '0;
		fm_w    = (int'(n) < WIDTH) ? (unit_w - 1'b1) : '1;
		half_w  = (n == '0) ? '0 :
			((int'(n) - 1 < WIDTH) ? (WIDTH'(1) << (n - 5'd1)) : '0);
		floor_w = a_w & ~fm_w;
		early   = '0;
		status  = qfa_pkg::STAT_OK;
		case (req.action)
			qfa_pkg::ACT_ADD: early = sum;
			qfa_pkg::ACT_SUB: early = diff;
			qfa_pkg::ACT_MUL, qfa_pkg::ACT_DIV: early = '0;
			qfa_pkg::ACT_CADD: begin
				early = sum;
				if (signed_mode ? ((a_w[WIDTH-1] == b_w[WIDTH-1]) &&
						(sum[WIDTH-1] != a_w[WIDTH-1])) : (sum < a_w))
					status = qfa_pkg::STAT_OVF;
			end
			qfa_pkg::ACT_CSUB: begin
				early = diff;
				if (signed_mode ? ((a_w[WIDTH-1] != b_w[WIDTH-1]) &&
						(diff[WIDTH-1] != a_w[WIDTH-1])) : (a_w < b_w))
					status = qfa_pkg::STAT_OVF;
			end
			qfa_pkg::ACT_CMUL: begin
				if (n_bad) status = qfa_pkg::STAT_INV;
			end
			qfa_pkg::ACT_CDIV: begin
				if (n_bad || bzero) status = qfa_pkg::STAT_INV;
			end
			qfa_pkg::ACT_CONV: begin
				if (nt > n) early = a_w << (nt - n);
				else if (nt < n) early = signed_mode ?
					WIDTH'($signed(a_w) >>> (n - nt)) : (a_w >> (n - nt));
				else early = a_w;
			end
			qfa_pkg::ACT_FLOOR, qfa_pkg::ACT_CEIL,
			qfa_pkg::ACT_ROUND, qfa_pkg::ACT_ABS: begin
				if (!signed_mode) begin
					status = qfa_pkg::STAT_INV;
				end else begin
					case (req.action)
						qfa_pkg::ACT_FLOOR: early = floor_w;
						qfa_pkg::ACT_CEIL:  early = floor_w +
							(((a_w & fm_w) != '0) ? unit_w : '0);
						qfa_pkg::ACT_ROUND: early = (n == '0) ? a_w :
							((a_w + half_w) & ~fm_w);
						default: early = a_w[WIDTH-1] ? (~a_w + 1'b1) : a_w;
					endcase
				end
			end
			default: status = qfa_pkg::STAT_INV;
		endcase
		// The divider consumes the dividend already scaled by 2^n.
		if (req.action == qfa_pkg::ACT_DIV || req.action == qfa_pkg::ACT_CDIV)
			num = NW'(ma) << n;
		else
			num = NW'(ma);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid      <= start;
			ctrl_s1.action     <= req.action;
			ctrl_s1.n          <= n;
			ctrl_s1.sgn        <= signed_mode;
			ctrl_s1.neg        <= a_neg ^ b_neg;
			ctrl_s1.bzero      <= bzero;
			ctrl_s1.status_pre <= status;
		end
	end

	always_ff @(posedge clk) begin
		num_s1   <= num;
		mb_s1    <= mb;
		early_s1 <= early;
	end

endmodule

`default_nettype wire

### rtl/core/qfa_cell.sv
// One cell of the multiply/divide chain: a restoring divide step and a
// shift-add multiply step on the bit leaving the top of the operand. Uses qfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qfa_cell #(
	parameter int WIDTH = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  qfa_pkg::qfa_ctrl_t ctrl_i,
	input  wire [WIDTH+qfa_pkg::FRAC_MAX-1:0] num_i,
	input  wire [WIDTH-1:0]    mb_i,
	input  wire [WIDTH-1:0]    rem_i,
	input  wire [2*WIDTH-1:0]  acc_i,
	input  wire [WIDTH-1:0]    early_i,
	output qfa_pkg::qfa_ctrl_t ctrl_q,
	output logic [WIDTH+qfa_pkg::FRAC_MAX-1:0] num_q,
	output logic [WIDTH-1:0]   mb_q,
	output logic [WIDTH-1:0]   rem_q,
	output logic [2*WIDTH-1:0] acc_q,
	output logic [WIDTH-1:0]   early_q
);

	localparam int NW = WIDTH + qfa_pkg::FRAC_MAX;

	logic             bit_in, ge;
	logic [WIDTH:0]   rem_sh, rem_sub;

	assign bit_in  = num_i[NW-1];
	assign rem_sh  = {rem_i, bit_in};
	assign rem_sub = rem_sh - {1'b0, mb_i};
	assign ge      = (rem_sh >= {1'b0, mb_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_i;
		end
	end

	// The quotient bit enters at the bottom as the dividend bit leaves the top.
	always_ff @(posedge clk) begin
		num_q   <= {num_i[NW-2:0], ge};
		rem_q   <= ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
		acc_q   <= {acc_i[2*WIDTH-2:0], 1'b0} +
			(bit_in ? {{WIDTH{1'b0}}, mb_i} : {(2*WIDTH){1'b0}});
		mb_q    <= mb_i;
		early_q <= early_i;
	end

endmodule

`default_nettype wire

### rtl/core/qfa_back.sv
// Output stages of the Q-format ALU: sign restore, floor shift of the product,
// range checks and result selection. Uses qfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qfa_back #(
	parameter int WIDTH = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  qfa_pkg::qfa_ctrl_t ctrl_i,
	input  wire [WIDTH+qfa_pkg::FRAC_MAX-1:0] quo_i,
	input  wire [2*WIDTH-1:0]  prod_i,
	input  wire [WIDTH-1:0]    early_i,
	output logic               done,
	output qfa_pkg::qfa_rsp_t  rsp
);

	localparam int NW = WIDTH + qfa_pkg::FRAC_MAX;

	qfa_pkg::qfa_ctrl_t ctrl_s1;
	logic [2*WIDTH:0]   ps_s1;
	logic [WIDTH-1:0]   div_val_s1, early_s1;
	logic               div_fit_s1;

	logic [NW-1:0]      lim;
	logic               div_fit, mul_fit;
	logic [2*WIDTH:0]   pext, r;
	logic [WIDTH-1:0]   res_v;
	logic [qfa_pkg::STAT_W-1:0] res_s;

	always_comb begin
		lim  = NW'(1) << (WIDTH - 1);
		if (ctrl_i.sgn)
			div_fit = ctrl_i.neg ? (quo_i <= lim) : (quo_i < lim);
		else
			div_fit = (quo_i < (NW'(1) << WIDTH));
		pext = {1'b0, prod_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		ps_s1      <= ctrl_i.neg ? (~pext + 1'b1) : pext;
		div_val_s1 <= ctrl_i.neg ? (~quo_i[WIDTH-1:0] + 1'b1) : quo_i[WIDTH-1:0];
		div_fit_s1 <= div_fit;
		early_s1   <= early_i;
	end

	always_comb begin
		// The product is negated for a negative result, so the arithmetic shift floors both signs.
		r = $unsigned($signed(ps_s1) >>> ctrl_s1.n);
		if (ctrl_s1.sgn)
			mul_fit = (&r[2*WIDTH:WIDTH-1]) | ~(|r[2*WIDTH:WIDTH-1]);
		else
			mul_fit = ~(|r[2*WIDTH:WIDTH]);
		res_v = '0;
		res_s = ctrl_s1.status_pre;
		case (ctrl_s1.action)
			qfa_pkg::ACT_MUL: begin
				res_v = r[WIDTH-1:0];
				res_s = qfa_pkg::STAT_OK;
			end
			qfa_pkg::ACT_DIV: begin
				res_v = ctrl_s1.bzero ? '0 : div_val_s1;
				res_s = qfa_pkg::STAT_OK;
			end
			qfa_pkg::ACT_CMUL: begin
				if (ctrl_s1.status_pre == qfa_pkg::STAT_OK) begin
					if (mul_fit) res_v = r[WIDTH-1:0];
					else res_s = qfa_pkg::STAT_OVF;
				end
			end
			qfa_pkg::ACT_CDIV: begin
				if (ctrl_s1.status_pre == qfa_pkg::STAT_OK) begin
					if (div_fit_s1) res_v = div_val_s1;
					else res_s = qfa_pkg::STAT_OVF;
				end
			end
			default: begin
				if (ctrl_s1.status_pre == qfa_pkg::STAT_OK) res_v = early_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctrl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp.value  <= qfa_pkg::FIELD_W'(res_v);
		rsp.status <= res_s;
	end

endmodule

`default_nettype wire

### rtl/core/q_format_fixed_point_alu.sv
// Q-format fixed-point ALU top level, built from one input stage, WIDTH+31
// multiply/divide cells and two output stages.
// Throughput is one request per cycle; busy is always low and every result is
// shown for one cycle with done. Reset clears the pipeline valid bits and sets
// frac_bits to 16 and signed_mode to 1. Depends on qfa_pkg and its submodules.
`timescale 1ns / 1ps
`default_nettype none

module q_format_fixed_point_alu #(
	parameter int WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  qfa_pkg::qfa_req_t            req,
	output logic                         done,
	output qfa_pkg::qfa_rsp_t            rsp,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [qfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [qfa_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NW = WIDTH + qfa_pkg::FRAC_MAX;

	logic [qfa_pkg::FRAC_W-1:0] frac_q;
	logic                       signed_q;

	qfa_pkg::qfa_ctrl_t ctrl_c  [0:NW];
	logic [NW-1:0]      num_c   [0:NW];
	logic [WIDTH-1:0]   mb_c    [0:NW];
	logic [WIDTH-1:0]   rem_c   [0:NW];
	logic [2*WIDTH-1:0] acc_c   [0:NW];
	logic [WIDTH-1:0]   early_c [0:NW];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q   <= qfa_pkg::FRAC_RESET;
			signed_q <= qfa_pkg::SIGNED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == qfa_pkg::REG_FRAC_BITS)
				frac_q <= cfg_data[qfa_pkg::FRAC_W-1:0];
			else if (cfg_index == qfa_pkg::REG_SIGNED_MODE)
				signed_q <= cfg_data[0];
		end
	end

	qfa_front #(.WIDTH(WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start & ~busy),
		.req         (req),
		.frac_bits   (frac_q),
		.signed_mode (signed_q),
		.ctrl_s1     (ctrl_c[0]),
		.num_s1      (num_c[0]),
		.mb_s1       (mb_c[0]),
		.early_s1    (early_c[0])
	);

	assign rem_c[0] = '0;
	assign acc_c[0] = '0;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		qfa_cell #(.WIDTH(WIDTH)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl_i  (ctrl_c[k]),
			.num_i   (num_c[k]),
			.mb_i    (mb_c[k]),
			.rem_i   (rem_c[k]),
			.acc_i   (acc_c[k]),
			.early_i (early_c[k]),
			.ctrl_q  (ctrl_c[k+1]),
			.num_q   (num_c[k+1]),
			.mb_q    (mb_c[k+1]),
			.rem_q   (rem_c[k+1]),
			.acc_q   (acc_c[k+1]),
			.early_q (early_c[k+1])
		);
	end

	qfa_back #(.WIDTH(WIDTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_i  (ctrl_c[NW]),
		.quo_i   (num_c[NW]),
		.prod_i  (acc_c[NW]),
		.early_i (early_c[NW]),
		.done    (done),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
